// File: hw/rtl/vrrb_pkg.sv
// Package: sizes, operation and status codes for the record ring buffer.
package vrrb_pkg;
   localparam int BUF_BYTES   = 65536;
   localparam int STORE_BYTES = BUF_BYTES + 2;
   localparam int PTR_W       = 17;
   localparam int LEN_W       = 15;
   localparam int HDR_W       = 16;
   localparam int MEM_AW      = $clog2(STORE_BYTES);
   localparam int STEP_W      = $clog2(STORE_BYTES + 1);

   localparam logic [2:0] FUNC_RESERVE = 3'd0;
   localparam logic [2:0] FUNC_WRITE   = 3'd1;
   localparam logic [2:0] FUNC_COMMIT  = 3'd2;
   localparam logic [2:0] FUNC_POP     = 3'd3;
   localparam logic [2:0] FUNC_READ    = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RESET = 2'd2;

   localparam logic [7:0] LOST_BIT_HI = 8'h80;

   function automatic logic in_store(input logic [PTR_W-1:0] a);
      return 32'(a) < 32'(STORE_BYTES);
   endfunction
endpackage

// File: hw/rtl/vrrb_mem.sv
// Record byte store: one write port, one registered read port.
module vrrb_mem
   import vrrb_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [MEM_AW-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [MEM_AW-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/variable_record_ring_buffer_unit.sv
// Top level: variable-length record ring buffer with sequencer over one byte store.
// One word is taken at a time; req_ready is high only while the unit is idle. All work goes
// through the store's one write port and one registered read port. Write byte stores the
// byte; read byte takes the registered byte. Commit checks the end against the front and
// writes the two header bytes; pop checks for empty, reads the header and reads again
// from the start on a wrap marker. Reserve checks for room; per discarded record it reads
// the header, updates the pointer, marks it lost and checks again. A wrap writes the wrap
// marker, first moving the front if it must go to the start. Each result waits in an
// output register until rsp_ready; the unit takes the next word the cycle after.
module variable_record_ring_buffer_unit
   import vrrb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_func,
   input  logic [LEN_W-1:0] req_length,
   input  logic [PTR_W-1:0] req_address,
   input  logic [7:0]       req_data,
   input  logic [PTR_W-1:0] req_end_offset,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [PTR_W-1:0] rsp_payload_addr,
   output logic [LEN_W-1:0] rsp_entry_size,
   output logic             rsp_lost_flag,
   output logic [7:0]       rsp_read_data
);
   typedef enum logic [4:0] {
      IDLE, DONE, WB, RB0, RB1,
      RSV_CHK, RSV_WRAP, WZ0, WZ1, WALK, WALK_UPD,
      HDR0, HDR1, HDR2, MARK0, MARK1,
      CMT, CW0, CW1, POP, POP_A, POP_B
   } state_type;

   state_type        state_ff, state_in, ret_ff, ret_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [PTR_W-1:0] address_ff, address_in;
   logic [7:0]       data_ff, data_in;
   logic [PTR_W-1:0] end_ff, end_in;
   logic [PTR_W-1:0] front_ff, front_in, back_ff, back_in;
   logic [PTR_W-1:0] hdr_addr_ff, hdr_addr_in;
   logic [HDR_W-1:0] hdr_ff, hdr_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic             rd_ok_ff, rd_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic [PTR_W-1:0] paddr_ff, paddr_in;
   logic [LEN_W-1:0] esize_ff, esize_in;
   logic             lost_ff, lost_in;
   logic [7:0]       rdata_ff, rdata_in;

   logic             mem_wr;
   logic [PTR_W-1:0] wr_ptr, rd_ptr;
   logic [7:0]       wr_byte, mem_rd;
   logic [7:0]       rd_byte;
   logic [PTR_W:0]   back_plus_len;
   logic [HDR_W-1:0] commit_len;
   logic [LEN_W-1:0] sz;

   vrrb_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (MEM_AW'(wr_ptr)),
      .wr_data (wr_byte),
      .rd_addr (MEM_AW'(rd_ptr)),
      .rd_data (mem_rd)
   );

   assign rd_byte       = rd_ok_ff ? mem_rd : 8'd0;
   assign back_plus_len = {1'b0, back_ff} + {{(PTR_W + 1 - LEN_W){1'b0}}, length_ff};
   assign commit_len    = HDR_W'(end_ff - back_ff);
   assign sz            = hdr_ff[LEN_W-1:0];

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      length_in    = length_ff;
      address_in   = address_ff;
      data_in      = data_ff;
      end_in       = end_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      hdr_addr_in  = hdr_addr_ff;
      hdr_in       = hdr_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      paddr_in     = paddr_ff;
      esize_in     = esize_ff;
      lost_in      = lost_ff;
      rdata_in     = rdata_ff;
      mem_wr       = 1'b0;
      wr_ptr       = back_ff;
      wr_byte      = 8'd0;
      rd_ptr       = hdr_addr_ff;

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               length_in  = req_length;
               address_in = req_address;
               data_in    = req_data;
               end_in     = req_end_offset;
               steps_in   = '0;
               status_in  = STATUS_OK;
               paddr_in   = '0;
               esize_in   = '0;
               lost_in    = 1'b0;
               rdata_in   = 8'd0;
               case (req_func)
                  FUNC_RESERVE: state_in = RSV_CHK;
                  FUNC_WRITE:   state_in = WB;
                  FUNC_COMMIT:  state_in = CMT;
                  FUNC_POP:     state_in = POP;
                  FUNC_READ:    state_in = RB0;
                  default: begin
                     state_in     = DONE;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         DONE: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = IDLE;
            end
         end
         WB: begin
            mem_wr       = in_store(address_ff);
            wr_ptr       = address_ff;
            wr_byte      = data_ff;
            state_in     = DONE;
            rsp_valid_in = 1'b1;
         end
         RB0: begin
            rd_ptr   = address_ff;
            state_in = RB1;
         end
         RB1: begin
            rdata_in     = rd_byte;
            state_in     = DONE;
            rsp_valid_in = 1'b1;
         end
         RSV_CHK: begin
            if (32'(back_plus_len) > 32'(BUF_BYTES)) begin
               if (front_ff > back_ff) begin
                  hdr_addr_in = '0;
                  ret_in      = RSV_WRAP;
                  state_in    = HDR0;
               end else begin
                  state_in = WZ0;
               end
            end else begin
               state_in = WALK;
            end
         end
         RSV_WRAP: begin
            front_in = PTR_W'(sz);
            ret_in   = WZ0;
            state_in = MARK0;
         end
         WZ0: begin
            mem_wr   = in_store(back_ff);
            wr_ptr   = back_ff;
            state_in = WZ1;
         end
         WZ1: begin
            mem_wr   = in_store(back_ff + 1'b1);
            wr_ptr   = back_ff + 1'b1;
            back_in  = '0;
            state_in = WALK;
         end
         WALK: begin
            if (back_plus_len > {1'b0, front_ff} && back_ff < front_ff &&
                32'(steps_ff) < 32'(STORE_BYTES)) begin
               hdr_addr_in = front_ff;
               ret_in      = WALK_UPD;
               state_in    = HDR0;
            end else begin
               paddr_in     = back_ff + PTR_W'(2);
               state_in     = DONE;
               rsp_valid_in = 1'b1;
            end
         end
         WALK_UPD: begin
            front_in = (sz == '0) ? '0 : front_ff + PTR_W'(sz);
            steps_in = steps_ff + 1'b1;
            ret_in   = WALK;
            state_in = MARK0;
         end
         HDR0: begin
            rd_ptr   = hdr_addr_ff;
            state_in = HDR1;
         end
         HDR1: begin
            rd_ptr      = hdr_addr_ff + 1'b1;
            hdr_in[7:0] = rd_byte;
            state_in    = HDR2;
         end
         HDR2: begin
            hdr_in[15:8] = rd_byte;
            state_in     = ret_ff;
         end
         MARK0: begin
            rd_ptr   = front_ff + 1'b1;
            state_in = MARK1;
         end
         MARK1: begin
            mem_wr   = in_store(front_ff + 1'b1);
            wr_ptr   = front_ff + 1'b1;
            wr_byte  = rd_byte | LOST_BIT_HI;
            state_in = ret_ff;
         end
         CMT: begin
            if (back_ff < front_ff && end_ff > front_ff) begin
               front_in     = '0;
               back_in      = '0;
               status_in    = STATUS_RESET;
               state_in     = DONE;
               rsp_valid_in = 1'b1;
            end else begin
               state_in = CW0;
            end
         end
         CW0: begin
            mem_wr   = in_store(back_ff);
            wr_ptr   = back_ff;
            wr_byte  = commit_len[7:0];
            state_in = CW1;
         end
         CW1: begin
            mem_wr       = in_store(back_ff + 1'b1);
            wr_ptr       = back_ff + 1'b1;
            wr_byte      = commit_len[15:8];
            back_in      = end_ff;
            state_in     = DONE;
            rsp_valid_in = 1'b1;
         end
         POP: begin
            if (front_ff == back_ff) begin
               status_in    = STATUS_EMPTY;
               state_in     = DONE;
               rsp_valid_in = 1'b1;
            end else begin
               hdr_addr_in = front_ff;
               ret_in      = POP_A;
               state_in    = HDR0;
            end
         end
         POP_A: begin
            if (hdr_ff == '0) begin
               front_in    = '0;
               hdr_addr_in = '0;
               ret_in      = POP_B;
               state_in    = HDR0;
            end else begin
               state_in = POP_B;
            end
         end
         POP_B: begin
            if (sz < LEN_W'(2)) begin
               front_in  = '0;
               back_in   = '0;
               status_in = STATUS_RESET;
            end else begin
               paddr_in = front_ff + PTR_W'(2);
               lost_in  = hdr_ff[HDR_W-1];
               esize_in = sz - LEN_W'(2);
               front_in = front_ff + PTR_W'(sz);
            end
            state_in     = DONE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = IDLE;
      endcase
      rd_ok_in = in_store(rd_ptr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         ret_ff       <= IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      length_ff   <= length_in;
      address_ff  <= address_in;
      data_ff     <= data_in;
      end_ff      <= end_in;
      hdr_addr_ff <= hdr_addr_in;
      hdr_ff      <= hdr_in;
      steps_ff    <= steps_in;
      rd_ok_ff    <= rd_ok_in;
      status_ff   <= status_in;
      paddr_ff    <= paddr_in;
      esize_ff    <= esize_in;
      lost_ff     <= lost_in;
      rdata_ff    <= rdata_in;
   end

   assign req_ready        = (state_ff == IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_payload_addr = paddr_ff;
   assign rsp_entry_size   = esize_ff;
   assign rsp_lost_flag    = lost_ff;
   assign rsp_read_data    = rdata_ff;
endmodule
